@@ sv/fpq_pkg.sv @@
// Shared types and constants for the five-level priority queue.
`default_nettype none
package fpq_pkg;

   localparam int DEPTH   = 16;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   localparam logic [2:0] PRIO_MIN = 3'd1;
   localparam logic [2:0] PRIO_MAX = 3'd5;

   typedef enum logic [2:0] {
      ST_PUSHED  = 3'd0,
      ST_POPPED  = 3'd1,
      ST_BADPRIO = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [2:0]         prio;
   } slot_type;

   // Operation broadcast to every cell in the row.
   typedef struct packed {
      logic               push;
      logic               pop;
      logic signed [31:0] value;
      logic [2:0]         prio;
   } cmd_type;

endpackage
`default_nettype wire

@@ sv/fpq_cell.sv @@
// One storage cell of the sorted shift-register queue.
`default_nettype none
module fpq_cell
   import fpq_pkg::*;
(
   input  wire logic     clock,
   input  wire cmd_type  cmd,
   input  wire logic     occupied,
   input  wire logic     left_keep,
   input  wire slot_type left_slot,
   input  wire slot_type right_slot,
   output slot_type      slot,
   output logic          keep
);

   slot_type slot_ff;
   slot_type slot_in;

   // An occupied cell whose priority number does not exceed the new one stays put on a push.
   assign keep = occupied && (slot_ff.prio <= cmd.prio);
   assign slot = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (cmd.push && !keep) begin
         if (left_keep) begin
            slot_in.value = cmd.value;
            slot_in.prio  = cmd.prio;
         end else begin
            slot_in = left_slot;
         end
      end else if (cmd.pop) begin
         slot_in = right_slot;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule
`default_nettype wire

@@ sv/five_level_priority_queue.sv @@
// Top level of the five-level sorted priority queue built from a row of cells.
`default_nettype none
// Usage:
//   An item is a push (req_op = 0) of req_value with req_priority_req, or a pop
//   (req_op = 1). It is taken at a rising edge where start is high and busy is
//   low. busy never rises, so one item is taken every cycle that start is high.
//   Every item gives exactly one result: rsp_valid is high for one cycle, in the
//   cycle after the item was taken, with rsp_status, rsp_out_value and
//   rsp_out_priority. The receiver cannot stall; results are never held.
//   Throughput is 1 item per cycle: each cell compares its
//   stored priority with the broadcast one and shifts in the same cycle.
//   A push with priority outside 1..5 reports invalid priority, a push into a
//   full queue reports full, a pop of an empty queue reports empty; none of
//   these changes the contents. Within one priority level entries leave in
//   arrival order.
//   Reset clears the entry count and the result strobe; the cell contents are
//   left as they are and are never read before being written.
module five_level_priority_queue
   import fpq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_op,
   input  wire logic signed [31:0] req_value,
   input  wire logic [2:0]         req_priority_req,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic signed [31:0]      rsp_out_value,
   output logic [2:0]              rsp_out_priority
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff;
   status_type         status_ff, status_in;
   logic signed [31:0] out_value_ff, out_value_in;
   logic [2:0]         out_prio_ff, out_prio_in;

   logic     accept, prio_ok, is_full, is_empty;
   cmd_type  cmd;
   slot_type slots [DEPTH];
   logic     keeps [DEPTH];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign prio_ok  = (req_priority_req >= PRIO_MIN) && (req_priority_req <= PRIO_MAX);
   assign is_full  = (count_ff == COUNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   assign cmd.push  = accept && !req_op && prio_ok && !is_full;
   assign cmd.pop   = accept && req_op && !is_empty;
   assign cmd.value = req_value;
   assign cmd.prio  = req_priority_req;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic     occ;
      logic     lkeep;
      slot_type lslot, rslot;

      assign occ = (COUNT_W'(i) < count_ff);
      if (i == 0) begin : g_first
         assign lkeep = 1'b1;
         assign lslot = slots[0];
      end else begin : g_mid
         assign lkeep = keeps[i-1];
         assign lslot = slots[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rslot = slots[i];
      end else begin : g_inner
         assign rslot = slots[i+1];
      end

      fpq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (occ),
         .left_keep  (lkeep),
         .left_slot  (lslot),
         .right_slot (rslot),
         .slot       (slots[i]),
         .keep       (keeps[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      status_in    = status_ff;
      out_value_in = '0;
      out_prio_in  = '0;
      if (accept) begin
         if (!req_op) begin
            priority if (!prio_ok) begin
               status_in = ST_BADPRIO;
            end else if (is_full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_PUSHED;
               count_in  = count_ff + COUNT_W'(1);
            end
         end else if (is_empty) begin
            status_in = ST_EMPTY;
         end else begin
            status_in    = ST_POPPED;
            out_value_in = slots[0].value;
            out_prio_in  = slots[0].prio;
            count_in     = count_ff - COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      out_value_ff <= out_value_in;
      out_prio_ff  <= out_prio_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_value    = out_value_ff;
   assign rsp_out_priority = out_prio_ff;

endmodule
`default_nettype wire

@@ tb/sv/five_level_priority_queue_tb.sv @@
// Self-checking testbench for the five-level sorted priority queue.
`timescale 1ns / 1ps
module five_level_priority_queue_tb
   import fpq_pkg::*;
();

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam int unsigned RANDOM_ITEMS = 1375;
   localparam int unsigned DRAIN_LIMIT  = 200;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] value;
      logic [2:0]         prio;
   } outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               req_op = OP_PUSH;
   logic signed [31:0] req_value = '0;
   logic [2:0]         req_priority_req = '0;
   logic               busy;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_out_value;
   logic [2:0]         rsp_out_priority;

   // Contents of the queue as the block should hold them, head first.
   slot_type    shadow_slots[$];
   outcome_type expected_outcomes[$];
   int unsigned failures = 0;

   five_level_priority_queue dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_value        (req_value),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_priority (rsp_out_priority)
   );

   always #5 clock = ~clock;

   // Applies one item to the shadow queue and returns the result it should give.
   function automatic outcome_type predict_outcome(input logic op,
                                                   input logic signed [31:0] value,
                                                   input logic [2:0] prio);
      outcome_type res;
      slot_type    entry;
      int          pos;
      res.status = ST_PUSHED;
      res.value  = '0;
      res.prio   = '0;
      if (op == OP_PUSH) begin
         // The priority check takes precedence over the full check.
         if (prio < PRIO_MIN || prio > PRIO_MAX) begin
            res.status = ST_BADPRIO;
         end else if (shadow_slots.size() >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_slots.size() && shadow_slots[pos].prio <= prio) pos++;
            entry.value = value;
            entry.prio  = prio;
            shadow_slots.insert(pos, entry);
         end
      end else if (shadow_slots.size() == 0) begin
         res.status = ST_EMPTY;
      end else begin
         entry      = shadow_slots.pop_front();
         res.status = ST_POPPED;
         res.value  = entry.value;
         res.prio   = entry.prio;
      end
      return res;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99, 0);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9, 0))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return -32'sd1;
         3: return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_bad_priority();
      case ($urandom_range(2, 0))
         0: return 3'd0;
         1: return 3'd6;
         default: return 3'd7;
      endcase
   endfunction

   // Drives one item, waits until it is taken, then idles for gap cycles.
   task automatic send_item(input logic op, input logic signed [31:0] value,
                            input logic [2:0] prio, input int unsigned gap);
      start            <= 1'b1;
      req_op           <= op;
      req_value        <= value;
      req_priority_req <= prio;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_outcomes.push_back(predict_outcome(op, value, prio));
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_and_bad_priority();
      send_item(OP_POP, 32'sh7FFF_FFFF, 3'd7, pick_gap());
      send_item(OP_PUSH, 32'sh8000_0000, 3'd0, pick_gap());
      send_item(OP_PUSH, 32'sh7FFF_FFFF, 3'd6, pick_gap());
      send_item(OP_PUSH, -32'sd1, 3'd7, pick_gap());
   endtask

   // Fills the queue with levels arriving out of order, then overflows it and pops three entries.
   task automatic test_fill_and_overflow();
      logic signed [31:0] value;
      logic [2:0]         prio;
      for (int i = 0; i < DEPTH; i++) begin
         case (i)
            0: value = 32'sh8000_0000;
            1: value = 32'sh7FFF_FFFF;
            2: value = 32'sd0;
            3: value = -32'sd1;
            4: value = 32'sh5555_5555;
            5: value = 32'shAAAA_AAAA;
            default: value = 32'sh1234_5600 + i;
         endcase
         prio = PRIO_MIN + 3'((i * 3) % 5);
         send_item(OP_PUSH, value, prio, pick_gap());
      end
      send_item(OP_PUSH, 32'sh0F0F_0F0F, 3'd7, pick_gap());
      send_item(OP_PUSH, 32'shF0F0_F0F0, PRIO_MIN, pick_gap());
      repeat (3) send_item(OP_POP, pick_value(), 3'd0, pick_gap());
   endtask

   // Episodes with their own push ratio and level spread, so that the queue
   // swings between empty and full and single levels pile up.
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned span;
      int unsigned push_pct;
      bit          steady;
      logic [2:0]  lo;
      logic [2:0]  hi;
      logic        op;
      logic [2:0]  prio;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         span     = $urandom_range(80, 20);
         push_pct = $urandom_range(90, 15);
         steady   = ($urandom_range(3, 0) == 0);
         if ($urandom_range(2, 0) == 0) begin
            lo = 3'($urandom_range(PRIO_MAX, PRIO_MIN));
            hi = ($urandom_range(1, 0) == 0 || lo == PRIO_MAX) ? lo : lo + 3'd1;
         end else begin
            lo = PRIO_MIN;
            hi = PRIO_MAX;
         end
         for (int k = 0; k < span; k++) begin
            if ($urandom_range(99, 0) < push_pct) begin
               op   = OP_PUSH;
               prio = ($urandom_range(9, 0) == 0) ? pick_bad_priority()
                                                  : 3'($urandom_range(hi, lo));
            end else begin
               op   = OP_POP;
               prio = 3'($urandom_range(7, 0));
            end
            send_item(op, pick_value(), prio, steady ? 0 : pick_gap());
            sent++;
         end
         if ($urandom_range(7, 0) == 0) wait_for_results();
      end
   endtask

   always @(posedge clock) begin : check_results
      outcome_type exp;
      if (!reset && rsp_valid) begin
         if (expected_outcomes.size() == 0) begin
            $error("unexpected result: status %0d value %0d priority %0d",
                   rsp_status, rsp_out_value, rsp_out_priority);
            failures++;
         end else begin
            exp = expected_outcomes.pop_front();
            if (rsp_status !== exp.status) begin
               $error("rsp_status mismatch: expected %0d, actual %0d", exp.status, rsp_status);
               failures++;
            end
            if (rsp_out_value !== exp.value) begin
               $error("rsp_out_value mismatch: expected %0d, actual %0d",
                      exp.value, rsp_out_value);
               failures++;
            end
            if (rsp_out_priority !== exp.prio) begin
               $error("rsp_out_priority mismatch: expected %0d, actual %0d",
                      exp.prio, rsp_out_priority);
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_bad_priority();
      test_fill_and_overflow();
      wait_for_results();
      test_random_traffic();
      start <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && expected_outcomes.size() != 0; n++) begin
         @(posedge clock);
      end
      if (expected_outcomes.size() != 0) begin
         $error("%0d expected results never arrived", expected_outcomes.size());
         failures++;
      end
      // Give a stray extra result the chance to show up.
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("five_level_priority_queue verification clean");
      end else begin
         $display("five_level_priority_queue verification failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("five_level_priority_queue verification failed");
      $finish;
   end

endmodule
